// ===== hw/rtl/eul_pkg.sv =====
// shared constants for the xyz euler rotation pipeline
`timescale 1ns / 1ps

package eul_pkg;

  // angle units: 1/64 degree
  localparam int TURN    = 23040;
  localparam int QUARTER = 5760;
  localparam int EIGHTH  = 2880;
  localparam int HALF    = 11520;

  // pi in q2.30, split as u*pi/half = u*THETA_A + u*THETA_B/half
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [18:0] THETA_A = 19'(PI_Q30 / 64'(HALF));
  localparam logic [12:0] THETA_B = 13'(PI_Q30 % 64'(HALF));

  // floor(v/45) for v below 2^17 as (v*DIV45_M) >> DIV45_S
  localparam int          DIV45_S = 23;
  localparam logic [17:0] DIV45_M = 18'(((64'd1 << DIV45_S) + 64'd44) / 64'd45);

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  // power series: divisor and the ceiling of its log2 for each term
  localparam int NSIN  = 5;
  localparam int NSTEP = 6;
  localparam int SIN_DIV [NSIN]  = '{6, 20, 42, 72, 110};
  localparam int SIN_LEN [NSIN]  = '{3, 5, 6, 7, 7};
  localparam int COS_DIV [NSTEP] = '{2, 12, 30, 56, 90, 132};
  localparam int COS_LEN [NSTEP] = '{1, 4, 5, 6, 7, 8};

  // cycles from the angle register to sine and cosine
  localparam int SC_LAT = 4 + 2 * NSTEP + 1;

endpackage

// ===== hw/rtl/eul_sincos.sv =====
// sine and cosine of an angle in 1/64 degree, q2.30, fully pipelined
`timescale 1ns / 1ps

module eul_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output logic signed [31:0] sn,
  output logic signed [31:0] cs
);

  localparam logic signed [16:0] TURN_S = 17'(eul_pkg::TURN);
  localparam logic [14:0] Q1 = 15'(eul_pkg::QUARTER);
  localparam logic [14:0] Q2 = 15'(2 * eul_pkg::QUARTER);
  localparam logic [14:0] Q3 = 15'(3 * eul_pkg::QUARTER);
  localparam logic [12:0] QT = 13'(eul_pkg::QUARTER);
  localparam logic [12:0] ET = 13'(eul_pkg::EIGHTH);
  localparam int          NS = eul_pkg::NSTEP;

  // range reduction
  logic signed [16:0] a_ext, a_r0, a_r1;
  logic [14:0] a_r;
  logic [1:0]  a_qc;
  logic [12:0] a_t;

  always_comb begin
    a_ext = {angle[15], angle};
    a_r0  = (a_ext < 17'sd0) ? a_ext + TURN_S : a_ext;
    if (a_r0 < 17'sd0) begin
      a_r1 = a_r0 + TURN_S;
    end else if (a_r0 >= TURN_S) begin
      a_r1 = a_r0 - TURN_S;
    end else begin
      a_r1 = a_r0;
    end
    a_r = a_r1[14:0];
    if (a_r < Q1) begin
      a_qc = 2'd0;
      a_t  = 13'(a_r);
    end else if (a_r < Q2) begin
      a_qc = 2'd1;
      a_t  = 13'(a_r - Q1);
    end else if (a_r < Q3) begin
      a_qc = 2'd2;
      a_t  = 13'(a_r - Q2);
    end else begin
      a_qc = 2'd3;
      a_t  = 13'(a_r - Q3);
    end
  end

  // tag = {swap, quadrant}
  logic [11:0] a_u;
  logic [2:0]  a_tag, b_tag, c_tag;
  logic [29:0] b_pa;
  logic [16:0] b_v;
  logic [29:0] c_theta;

  always_ff @(posedge clk) begin
    if (en) begin
      a_u   <= (a_t <= ET) ? 12'(a_t) : 12'(QT - a_t);
      a_tag <= {(a_t > ET), a_qc};
      b_pa  <= 30'(31'(a_u) * 31'(eul_pkg::THETA_A));
      b_v   <= 17'((25'(a_u) * 25'(eul_pkg::THETA_B) + 25'(eul_pkg::QUARTER)) >> 8);
      b_tag <= a_tag;
      c_theta <= b_pa + 30'((35'(b_v) * 35'(eul_pkg::DIV45_M)) >> eul_pkg::DIV45_S);
      c_tag   <= b_tag;
    end
  end

  // series steps
  logic [29:0]        t_x2  [0:NS];
  logic [30:0]        s_term[0:NS];
  logic [30:0]        c_term[0:NS];
  logic signed [31:0] s_sum [0:NS];
  logic signed [31:0] c_sum [0:NS];
  logic [2:0]         t_tag [0:NS];

  logic [29:0]        m_x2  [0:NS-1];
  logic [30:0]        m_s   [0:NS-1];
  logic [30:0]        m_c   [0:NS-1];
  logic signed [31:0] m_ssum[0:NS-1];
  logic signed [31:0] m_csum[0:NS-1];
  logic [2:0]         m_tag [0:NS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      t_x2[0]   <= 30'((60'(c_theta) * 60'(c_theta)) >> 30);
      s_term[0] <= 31'(c_theta);
      c_term[0] <= 31'(eul_pkg::ONE_Q30);
      s_sum[0]  <= 32'(c_theta);
      c_sum[0]  <= eul_pkg::ONE_Q30;
      t_tag[0]  <= c_tag;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam int          CD   = eul_pkg::COS_DIV[i];
    localparam int          CSH  = 30 + eul_pkg::COS_LEN[i];
    localparam logic [63:0] CREC = ((64'd1 << CSH) + 64'(CD) - 64'd1) / 64'(CD);
    localparam bit          NEG  = (i % 2) == 0;

    logic [62:0] c_prod;
    logic [30:0] c_new;

    always_comb begin
      c_prod = 63'(m_c[i]) * 63'(CREC[31:0]);
      c_new  = 31'(c_prod >> CSH);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_x2[i]   <= t_x2[i];
        m_s[i]    <= 31'((61'(s_term[i]) * 61'(t_x2[i])) >> 30);
        m_c[i]    <= 31'((61'(c_term[i]) * 61'(t_x2[i])) >> 30);
        m_ssum[i] <= s_sum[i];
        m_csum[i] <= c_sum[i];
        m_tag[i]  <= t_tag[i];
        t_x2[i+1]   <= m_x2[i];
        c_term[i+1] <= c_new;
        c_sum[i+1]  <= NEG ? m_csum[i] - 32'(c_new) : m_csum[i] + 32'(c_new);
        t_tag[i+1]  <= m_tag[i];
      end
    end

    if (i < eul_pkg::NSIN) begin : g_sin
      localparam int          SD   = eul_pkg::SIN_DIV[i];
      localparam int          SSH  = 30 + eul_pkg::SIN_LEN[i];
      localparam logic [63:0] SREC = ((64'd1 << SSH) + 64'(SD) - 64'd1) / 64'(SD);

      logic [62:0] s_prod;
      logic [30:0] s_new;

      always_comb begin
        s_prod = 63'(m_s[i]) * 63'(SREC[31:0]);
        s_new  = 31'(s_prod >> SSH);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          s_term[i+1] <= s_new;
          s_sum[i+1]  <= NEG ? m_ssum[i] - 32'(s_new) : m_ssum[i] + 32'(s_new);
        end
      end
    end else begin : g_pass
      // sine series is complete, hold the sum alongside the cosine step
      always_ff @(posedge clk) begin
        if (en) begin
          s_term[i+1] <= m_s[i];
          s_sum[i+1]  <= m_ssum[i];
        end
      end
    end
  end

  // octant swap and quadrant signs
  logic signed [31:0] e_s0, e_c0;

  always_comb begin
    e_s0 = t_tag[NS][2] ? c_sum[NS] : s_sum[NS];
    e_c0 = t_tag[NS][2] ? s_sum[NS] : c_sum[NS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (t_tag[NS][1:0])
        2'd0: begin
          sn <= e_s0;
          cs <= e_c0;
        end
        2'd1: begin
          sn <= e_c0;
          cs <= -e_s0;
        end
        2'd2: begin
          sn <= -e_s0;
          cs <= -e_c0;
        end
        default: begin
          sn <= -e_c0;
          cs <= e_s0;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/euler_rotate_xyz.sv =====
// top level: rotation of a q16.16 point about x, then y, then z
`timescale 1ns / 1ps

// Rotates one point (x, y, z in signed q16.16) by three angles in signed
// 1/64 degree units, first about x, then y, then z, right-handed. Sine and
// cosine come from a fixed power series evaluated in a pipeline, one lane
// per angle; each rotation rounds its products half away from zero and only
// the final coordinates saturate to the 32-bit range. Zero angles pass the
// point through unchanged. One transaction is taken every clock cycle while
// the output is not stalled; each passes through the input register, the
// sine and cosine series, a product register and a rounded-sum register per
// rotation axis, and the output register. The pipeline advances as a whole:
// it moves whenever the output register is empty or being taken, so a
// stalled result stops every stage and nothing is dropped or repeated.
// Angles outside one full turn are reduced modulo a turn.
module euler_rotate_xyz (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // in_x, in_y, in_z (32 each), angle_x, angle_y, angle_z (16 each)
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x, out_y, out_z (32 each)
  output logic [95:0]  m_tdata
);

  localparam int LAT   = eul_pkg::SC_LAT;
  localparam int DEPTH = LAT + 8;

  // whole pipeline advances together
  logic en;
  logic vld [0:DEPTH-1];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // input register
  logic signed [31:0] px [0:LAT];
  logic signed [31:0] py [0:LAT];
  logic signed [31:0] pz [0:LAT];
  logic signed [15:0] ang_x, ang_y, ang_z;

  always_ff @(posedge clk) begin
    if (en) begin
      px[0] <= s_tdata[31:0];
      py[0] <= s_tdata[63:32];
      pz[0] <= s_tdata[95:64];
      ang_x <= s_tdata[111:96];
      ang_y <= s_tdata[127:112];
      ang_z <= s_tdata[143:128];
      for (int i = 1; i <= LAT; i++) begin
        px[i] <= px[i-1];
        py[i] <= py[i-1];
        pz[i] <= pz[i-1];
      end
    end
  end

  // sine and cosine lanes, aligned with px[LAT]
  logic signed [31:0] sn_x, cs_x, sn_y, cs_y, sn_z, cs_z;

  eul_sincos u_sc_x (.clk(clk), .en(en), .angle(ang_x), .sn(sn_x), .cs(cs_x));
  eul_sincos u_sc_y (.clk(clk), .en(en), .angle(ang_y), .sn(sn_y), .cs(cs_y));
  eul_sincos u_sc_z (.clk(clk), .en(en), .angle(ang_z), .sn(sn_z), .cs(cs_z));

  // y lane is delayed to meet the y rotation, z lane to meet the z rotation
  logic signed [31:0] sy_d [0:1];
  logic signed [31:0] cy_d [0:1];
  logic signed [31:0] sz_d [0:3];
  logic signed [31:0] cz_d [0:3];

  always_ff @(posedge clk) begin
    if (en) begin
      sy_d[0] <= sn_y;
      cy_d[0] <= cs_y;
      sy_d[1] <= sy_d[0];
      cy_d[1] <= cy_d[0];
      sz_d[0] <= sn_z;
      cz_d[0] <= cs_z;
      for (int i = 1; i < 4; i++) begin
        sz_d[i] <= sz_d[i-1];
        cz_d[i] <= cz_d[i-1];
      end
    end
  end

  // round p / 2^30 half away from zero
  function automatic logic signed [34:0] rnd30(input logic signed [67:0] p);
    logic signed [67:0] adj;
    begin
      adj = p + 68'sd536870912 - (p[67] ? 68'sd1 : 68'sd0);
      rnd30 = 35'(adj >>> 30);
    end
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    begin
      if (v > 35'sd2147483647) begin
        sat32 = 32'h7fff_ffff;
      end else if (v < -35'sd2147483648) begin
        sat32 = 32'h8000_0000;
      end else begin
        sat32 = v[31:0];
      end
    end
  endfunction

  // rotation stages: products, then rounded sums
  logic signed [66:0] rx_p0, rx_p1, rx_p2, rx_p3;
  logic signed [66:0] ry_p0, ry_p1, ry_p2, ry_p3;
  logic signed [66:0] rz_p0, rz_p1, rz_p2, rz_p3;
  logic signed [34:0] rx_x, ry_y, rz_z;
  logic signed [34:0] xa_x, xa_y, xa_z;
  logic signed [34:0] ya_x, ya_y, ya_z;
  logic signed [34:0] za_x, za_y, za_z;

  always_ff @(posedge clk) begin
    if (en) begin
      // about x: y' = y*c - z*s, z' = y*s + z*c
      rx_p0 <= 67'(py[LAT]) * 67'(cs_x);
      rx_p1 <= 67'(pz[LAT]) * 67'(sn_x);
      rx_p2 <= 67'(py[LAT]) * 67'(sn_x);
      rx_p3 <= 67'(pz[LAT]) * 67'(cs_x);
      rx_x  <= 35'(px[LAT]);
      xa_x  <= rx_x;
      xa_y  <= rnd30(68'(rx_p0) - 68'(rx_p1));
      xa_z  <= rnd30(68'(rx_p2) + 68'(rx_p3));
      // about y: z' = z*c - x*s, x' = z*s + x*c
      ry_p0 <= 67'(xa_z) * 67'(cy_d[1]);
      ry_p1 <= 67'(xa_x) * 67'(sy_d[1]);
      ry_p2 <= 67'(xa_z) * 67'(sy_d[1]);
      ry_p3 <= 67'(xa_x) * 67'(cy_d[1]);
      ry_y  <= xa_y;
      ya_y  <= ry_y;
      ya_z  <= rnd30(68'(ry_p0) - 68'(ry_p1));
      ya_x  <= rnd30(68'(ry_p2) + 68'(ry_p3));
      // about z: x' = x*c - y*s, y' = x*s + y*c
      rz_p0 <= 67'(ya_x) * 67'(cz_d[3]);
      rz_p1 <= 67'(ya_y) * 67'(sz_d[3]);
      rz_p2 <= 67'(ya_x) * 67'(sz_d[3]);
      rz_p3 <= 67'(ya_y) * 67'(cz_d[3]);
      rz_z  <= ya_z;
      za_z  <= rz_z;
      za_x  <= rnd30(68'(rz_p0) - 68'(rz_p1));
      za_y  <= rnd30(68'(rz_p2) + 68'(rz_p3));
      // output register with saturation
      m_tdata <= {sat32(za_z), sat32(za_y), sat32(za_x)};
    end
  end

`ifndef SYNTHESIS
  // a held result freezes every stage
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(vld[0]) && $stable(vld[LAT]) && $stable(m_tdata))
    else $error("pipeline moved while output stalled");

  // x lane series output never exceeds one in magnitude
  a_sin_bound: assert property (@(posedge clk) disable iff (rst)
    vld[LAT] |-> (sn_x <= eul_pkg::ONE_Q30) && (sn_x >= -eul_pkg::ONE_Q30)
              && (cs_x <= eul_pkg::ONE_Q30) && (cs_x >= -eul_pkg::ONE_Q30))
    else $error("sine or cosine out of range");

  // a transaction in the stage before the output reaches it when the pipeline advances
  a_latency: assert property (@(posedge clk) disable iff (rst)
    vld[DEPTH-2] && en |=> m_tvalid)
    else $error("transaction lost in pipeline");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
